FILE: sv/art_pkg.sv
`timescale 1ns / 1ps

package art_pkg;

    // item modes
    typedef enum logic [1:0] {
        MODE_DEFINE     = 2'd0,
        MODE_LOAD_BEGIN = 2'd1,
        MODE_LOAD_END   = 2'd2,
        MODE_LOOKUP     = 2'd3
    } t_mode;

    // lookup classes
    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_CODE   = 2'd1,
        KIND_STACK  = 2'd2,
        KIND_KERNEL = 2'd3
    } t_kind;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // read, write and execute
    localparam logic [2:0] PERM_ALL = 3'b111;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEF_PREP,
        ST_DEF_SCAN,
        ST_DEF_INS,
        ST_LOAD,
        ST_LOOK,
        ST_DONE
    } t_state;

    // one input beat
    typedef struct packed {
        t_mode       mode;
        logic [31:0] address;
        logic [31:0] region_length;
        logic [2:0]  perms;
    } t_item;

    // one result beat
    typedef struct packed {
        logic        status;
        t_kind       seg_kind;
        logic [2:0]  perms;
        logic        found;
    } t_result;

    // one table entry as stored in memory
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] length;
        logic [2:0]  perms;
        logic [2:0]  saved_perms;
        logic        stack_mark;
    } t_entry;

endpackage

FILE: sv/art_ram.sv
`timescale 1ns / 1ps

module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/art_engine.sv
`timescale 1ns / 1ps

module art_engine #(
    parameter int MAX_REGIONS = 8,
    parameter int PAGE_BITS   = 12,
    parameter int IDX_W       = 3,
    parameter int CNT_W       = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  art_pkg::t_item     i_item,
    input  logic [31:0]        i_stack_top,
    output logic               o_idle,
    output logic               o_res_vld,
    output art_pkg::t_result   o_res,
    input  logic               i_res_take,
    output logic               o_ram_we,
    output logic [IDX_W-1:0]   o_ram_waddr,
    output art_pkg::t_entry    o_ram_wdata,
    output logic [IDX_W-1:0]   o_ram_raddr,
    input  art_pkg::t_entry    i_ram_rdata
);

    import art_pkg::*;

    localparam logic [31:0] PAGE_MASK = (32'd1 << PAGE_BITS) - 32'd1;

    // bounds of one entry, precomputed ahead of the lookup compares
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] s;      // base - length for stack, base + length otherwise
        logic [31:0] q;      // base - length - 1
        logic [2:0]  perms;
        logic        stack_mark;
    } t_bnd;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_mode            r_mode, n_mode;
    logic [31:0]      r_addr, n_addr;
    t_entry           r_new, n_new;
    logic [31:0]      r_size1, n_size1;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_iss, n_iss;
    logic             r_a_vld, n_a_vld;
    logic [IDX_W-1:0] r_a_idx, n_a_idx;
    logic             r_b_vld, n_b_vld;
    logic [IDX_W-1:0] r_b_idx, n_b_idx;
    t_bnd             r_b, n_b;
    t_result          r_res, n_res;
    logic             r_kdone, n_kdone;
    logic             r_pdone, n_pdone;

    logic [CNT_W-1:0] cnt_last;
    logic [IDX_W-1:0] last_idx;
    logic [CNT_W-1:0] idx_next;
    logic [IDX_W-1:0] a_up;
    t_entry           ent;
    logic             kind_hit;
    logic             perm_hit;
    logic             kd, pd;

    assign cnt_last = r_count - CNT_W'(1);
    assign last_idx = cnt_last[IDX_W-1:0];
    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign a_up     = IDX_W'(CNT_W'(r_a_idx) + CNT_W'(1));
    assign ent      = i_ram_rdata;

    // range checks on the entry held in the compare stage
    always_comb begin
        if (r_b.stack_mark) begin
            kind_hit = (r_addr >= r_b.q) && (r_addr <= r_b.base);
            perm_hit = (r_addr > r_b.s) && (r_addr < r_b.base);
        end else begin
            kind_hit = (r_addr >= r_b.base) && ((r_b.s == 32'd0) || (r_addr < r_b.s));
            perm_hit = (r_addr >= r_b.base) && (r_addr < r_b.s);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_iss   <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            r_iss   <= n_iss;
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
        end
        r_mode  <= n_mode;
        r_addr  <= n_addr;
        r_new   <= n_new;
        r_size1 <= n_size1;
        r_idx   <= n_idx;
        r_a_idx <= n_a_idx;
        r_b_idx <= n_b_idx;
        r_b     <= n_b;
        r_res   <= n_res;
        r_kdone <= n_kdone;
        r_pdone <= n_pdone;
    end

    // next state, memory access and result gathering
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mode      = r_mode;
        n_addr      = r_addr;
        n_new       = r_new;
        n_size1     = r_size1;
        n_idx       = r_idx;
        n_iss       = 1'b0;
        n_a_vld     = 1'b0;
        n_a_idx     = r_a_idx;
        n_b_vld     = 1'b0;
        n_b_idx     = r_b_idx;
        n_b         = r_b;
        n_res       = r_res;
        n_kdone     = r_kdone;
        n_pdone     = r_pdone;
        kd          = r_kdone;
        pd          = r_pdone;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_a_idx;
        o_ram_wdata = r_new;
        o_ram_raddr = r_idx;
        o_res_vld   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_mode  = i_item.mode;
                    n_addr  = i_item.address;
                    n_res   = '0;
                    n_kdone = 1'b0;
                    n_pdone = 1'b0;
                    n_idx   = '0;
                    unique case (i_item.mode)
                        MODE_DEFINE: begin
                            if (r_count >= CNT_W'(MAX_REGIONS)) begin
                                n_res.status = STATUS_FULL;
                                n_state      = ST_DONE;
                            end else begin
                                n_new.base        = i_item.address & ~PAGE_MASK;
                                n_new.perms       = i_item.perms;
                                n_new.saved_perms = i_item.perms;
                                n_size1 = i_item.region_length + (i_item.address & PAGE_MASK);
                                n_state = ST_DEF_PREP;
                            end
                        end
                        MODE_LOAD_BEGIN, MODE_LOAD_END: begin
                            if (r_count == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                n_iss   = 1'b1;
                                n_state = ST_LOAD;
                            end
                        end
                        MODE_LOOKUP: begin
                            if (i_item.address >= i_stack_top) begin
                                n_kdone        = 1'b1;
                                n_res.seg_kind = KIND_KERNEL;
                            end
                            if (r_count == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                n_iss   = 1'b1;
                                n_state = ST_LOOK;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            // round the size to whole pages and mark the stack region
            ST_DEF_PREP: begin
                n_new.length     = (r_size1 + PAGE_MASK) & ~PAGE_MASK;
                n_new.stack_mark = (r_new.base == i_stack_top);
                if (r_count == '0) begin
                    n_state = ST_DEF_INS;
                end else begin
                    n_idx   = last_idx;
                    n_iss   = 1'b1;
                    n_state = ST_DEF_SCAN;
                end
            end

            // walk down from the top, moving entries up one slot until the
            // insertion point; an occupied slot is written only after it was read
            ST_DEF_SCAN: begin
                if (r_iss) begin
                    n_a_vld = 1'b1;
                    n_a_idx = r_idx;
                    n_idx   = r_idx - IDX_W'(1);
                    n_iss   = (r_idx != '0);
                end
                if (r_a_vld) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = a_up;
                    if (ent.base >= r_new.base) begin
                        o_ram_wdata = ent;
                        if (r_a_idx == '0) begin
                            n_iss   = 1'b0;
                            n_a_vld = 1'b0;
                            n_state = ST_DEF_INS;
                        end
                    end else begin
                        o_ram_wdata = r_new;
                        n_count     = r_count + CNT_W'(1);
                        n_iss       = 1'b0;
                        n_a_vld     = 1'b0;
                        n_state     = ST_DONE;
                    end
                end
            end

            // new region goes to the bottom slot
            ST_DEF_INS: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = '0;
                o_ram_wdata = r_new;
                n_count     = r_count + CNT_W'(1);
                n_state     = ST_DONE;
            end

            // save or restore permissions entry by entry
            ST_LOAD: begin
                if (r_iss) begin
                    n_a_vld = 1'b1;
                    n_a_idx = r_idx;
                    n_idx   = idx_next[IDX_W-1:0];
                    n_iss   = (idx_next < r_count);
                end
                if (r_a_vld) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_a_idx;
                    o_ram_wdata = ent;
                    if (r_mode == MODE_LOAD_BEGIN) begin
                        o_ram_wdata.saved_perms = ent.perms;
                        o_ram_wdata.perms       = PERM_ALL;
                    end else begin
                        o_ram_wdata.perms = ent.saved_perms;
                    end
                    if (r_a_idx == last_idx) begin
                        n_iss   = 1'b0;
                        n_a_vld = 1'b0;
                        n_state = ST_DONE;
                    end
                end
            end

            // read, bound, compare: first hit wins for class and permission
            ST_LOOK: begin
                if (r_iss) begin
                    n_a_vld = 1'b1;
                    n_a_idx = r_idx;
                    n_idx   = idx_next[IDX_W-1:0];
                    n_iss   = (idx_next < r_count);
                end
                if (r_a_vld) begin
                    n_b_vld        = 1'b1;
                    n_b_idx        = r_a_idx;
                    n_b.base       = ent.base;
                    n_b.s          = ent.stack_mark ? (ent.base - ent.length)
                                                    : (ent.base + ent.length);
                    n_b.q          = ent.base + ~ent.length;
                    n_b.perms      = ent.perms;
                    n_b.stack_mark = ent.stack_mark;
                end
                if (r_b_vld) begin
                    if (!kd && kind_hit) begin
                        n_res.seg_kind = r_b.stack_mark ? KIND_STACK : KIND_CODE;
                        kd = 1'b1;
                    end
                    // a stack entry ends the permission search either way
                    if (!pd && (r_b.stack_mark || perm_hit)) begin
                        pd = 1'b1;
                        if (perm_hit) begin
                            n_res.found = 1'b1;
                            n_res.perms = r_b.perms;
                        end
                    end
                    n_kdone = kd;
                    n_pdone = pd;
                    if ((r_b_idx == last_idx) || (kd && pd)) begin
                        n_iss   = 1'b0;
                        n_a_vld = 1'b0;
                        n_b_vld = 1'b0;
                        n_state = ST_DONE;
                    end
                end
            end

            // hold the result until the output register takes it
            ST_DONE: begin
                o_res_vld = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_res  = r_res;

endmodule

FILE: sv/address_region_table.sv
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// in      | input     | i_in_valid / o_in_stall  | i_mode, i_address, i_region_length, i_perms_in
// out     | output    | o_out_valid / i_out_stall | o_status, o_seg_kind, o_perms_out, o_perms_found
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (stack top)
//
// One item at a time; the table lives in one RAM with one read and one write port,
// and every mode walks it at one entry per cycle. A lookup takes each entry through
// read, bound and compare stages. A full-table define or a load or lookup on an empty
// table goes straight to the result without walking the table.
// Reset empties the table and sets the stack top to 0x80000000; the RAM is not cleared.
// A result waits in the output register under stall while the next item is taken.

module address_region_table #(
    parameter int MAX_REGIONS = 8,
    parameter int PAGE_BITS   = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_address,
    input  logic [31:0] i_region_length,
    input  logic [2:0]  i_perms_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [1:0]  o_seg_kind,
    output logic [2:0]  o_perms_out,
    output logic        o_perms_found,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    import art_pkg::*;

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    logic             eng_idle;
    logic             in_beat;
    t_item            item;
    logic             res_vld;
    t_result          res;
    logic             res_take;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;
    logic [31:0]      r_stack_top;
    logic             r_out_vld;
    t_result          r_out;

    // stack top register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_top <= 32'h8000_0000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stack_top <= i_cfg_data;
        end
    end

    // input beat
    assign o_in_stall         = !eng_idle;
    assign in_beat            = i_in_valid && !o_in_stall;
    assign item.mode          = t_mode'(i_mode);
    assign item.address       = i_address;
    assign item.region_length = i_region_length;
    assign item.perms         = i_perms_in;

    art_engine #(
        .MAX_REGIONS(MAX_REGIONS),
        .PAGE_BITS  (PAGE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_beat),
        .i_item     (item),
        .i_stack_top(r_stack_top),
        .o_idle     (eng_idle),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_take (res_take),
        .o_ram_we   (ram_we),
        .o_ram_waddr(ram_waddr),
        .o_ram_wdata(ram_wdata),
        .o_ram_raddr(ram_raddr),
        .i_ram_rdata(ram_rdata)
    );

    art_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(MAX_REGIONS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // output register, loads when empty or draining
    assign res_take = res_vld && (!r_out_vld || !i_out_stall);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out.status;
    assign o_seg_kind    = r_out.seg_kind;
    assign o_perms_out   = r_out.perms;
    assign o_perms_found = r_out.found;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import art_pkg::*;

    localparam int          TBL_DEPTH    = 8;
    localparam int          PAGE_SHIFT   = 12;
    localparam logic [31:0] PAGE_MASK    = (32'd1 << PAGE_SHIFT) - 32'd1;
    localparam logic [31:0] STACK_TOP_RV = 32'h8000_0000;
    localparam int          PHASE_BEATS  = 238;
    localparam int          DRAIN_CYCLES = 16;

    // one directed row: input beat plus an optional typed-in result
    typedef struct packed {
        t_item   item;
        bit      pinned;
        t_result res;
    } t_dir_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_mode          = MODE_LOOKUP;
    logic [31:0] i_address       = 32'd0;
    logic [31:0] i_region_length = 32'd0;
    logic [2:0]  i_perms_in      = 3'd0;
    logic        i_out_stall     = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [31:0] i_cfg_data      = 32'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_status;
    logic [1:0]  o_seg_kind;
    logic [2:0]  o_perms_out;
    logic        o_perms_found;
    logic        o_cfg_ready;

    // typed-in result travelling with the beat on the input side
    bit          beat_pinned  = 1'b0;
    t_result     beat_pin_res = '0;

    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int          mismatch_count = 0;

    // mirror of the region table
    logic [31:0] rgn_base  [TBL_DEPTH];
    logic [31:0] rgn_len   [TBL_DEPTH];
    logic [2:0]  rgn_perms [TBL_DEPTH];
    logic [2:0]  rgn_saved [TBL_DEPTH];
    bit          rgn_stack [TBL_DEPTH];
    int          rgn_count       = 0;
    logic [31:0] model_stack_top = STACK_TOP_RV;

    t_result     pending_results [$];

    address_region_table #(
        .MAX_REGIONS (TBL_DEPTH),
        .PAGE_BITS   (PAGE_SHIFT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_address       (i_address),
        .i_region_length (i_region_length),
        .i_perms_in      (i_perms_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_seg_kind      (o_seg_kind),
        .o_perms_out     (o_perms_out),
        .o_perms_found   (o_perms_found),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // run limit
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // region class of an address under the current stack top
    function automatic t_kind classify_addr(logic [31:0] a);
        logic [31:0] lo;
        logic [31:0] hi;
        if (a >= model_stack_top) return KIND_KERNEL;
        for (int i = 0; i < rgn_count; i++) begin
            if (rgn_stack[i]) begin
                lo = rgn_base[i] - rgn_len[i] - 32'd1;
                hi = rgn_base[i];
            end else begin
                lo = rgn_base[i];
                hi = rgn_base[i] + rgn_len[i] - 32'd1;
            end
            if (a >= lo && a <= hi) return rgn_stack[i] ? KIND_STACK : KIND_CODE;
        end
        return KIND_UNUSED;
    endfunction

    // permission lookup; the first stack region ends the scan
    function automatic t_result perm_lookup(logic [31:0] a);
        t_result     r;
        logic [31:0] b;
        logic [31:0] lim;
        r = '0;
        for (int i = 0; i < rgn_count; i++) begin
            b = rgn_base[i];
            if (rgn_stack[i]) begin
                lim = b - rgn_len[i];
                if (a < b && a > lim) begin
                    r.perms = rgn_perms[i];
                    r.found = 1'b1;
                end
                return r;
            end
            lim = b + rgn_len[i];
            if (a >= b && a < lim) begin
                r.perms = rgn_perms[i];
                r.found = 1'b1;
                return r;
            end
        end
        return r;
    endfunction

    // apply one accepted beat to the table mirror and return its result
    function automatic t_result predict_region_result(t_item it);
        t_result     r;
        logic [31:0] span;
        logic [31:0] start;
        int          slot;
        r = '0;
        case (it.mode)
            MODE_DEFINE: begin
                if (rgn_count >= TBL_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    span  = it.region_length + (it.address & PAGE_MASK);
                    start = it.address & ~PAGE_MASK;
                    span  = (span + PAGE_MASK) & ~PAGE_MASK;
                    slot  = 0;
                    while (slot < rgn_count && rgn_base[slot] < start) slot++;
                    for (int k = rgn_count; k > slot; k--) begin
                        rgn_base[k]  = rgn_base[k-1];
                        rgn_len[k]   = rgn_len[k-1];
                        rgn_perms[k] = rgn_perms[k-1];
                        rgn_saved[k] = rgn_saved[k-1];
                        rgn_stack[k] = rgn_stack[k-1];
                    end
                    rgn_base[slot]  = start;
                    rgn_len[slot]   = span;
                    rgn_perms[slot] = it.perms;
                    rgn_saved[slot] = it.perms;
                    rgn_stack[slot] = (start == model_stack_top);
                    rgn_count++;
                    r.status = STATUS_OK;
                end
            end
            MODE_LOAD_BEGIN: begin
                for (int k = 0; k < rgn_count; k++) begin
                    rgn_saved[k] = rgn_perms[k];
                    rgn_perms[k] = PERM_ALL;
                end
            end
            MODE_LOAD_END: begin
                for (int k = 0; k < rgn_count; k++) rgn_perms[k] = rgn_saved[k];
            end
            default: begin
                r = perm_lookup(it.address);
                r.seg_kind = classify_addr(it.address);
            end
        endcase
        return r;
    endfunction

    // result check, config tracking and prediction at the clock edge
    always @(posedge i_clk) begin : beat_monitor
        t_result got;
        t_result want;
        t_item   acc;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.status   = o_status;
                got.seg_kind = t_kind'(o_seg_kind);
                got.perms    = o_perms_out;
                got.found    = o_perms_found;
                if (pending_results.size() == 0) begin
                    flag_mismatch("result beat with nothing pending", 32'(got), 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.seg_kind !== want.seg_kind)
                        flag_mismatch("seg_kind", 32'(got.seg_kind), 32'(want.seg_kind));
                    if (got.perms !== want.perms)
                        flag_mismatch("perms_out", 32'(got.perms), 32'(want.perms));
                    if (got.found !== want.found)
                        flag_mismatch("perms_found", 32'(got.found), 32'(want.found));
                end
            end
            if (i_cfg_valid && o_cfg_ready) model_stack_top = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                acc.mode          = t_mode'(i_mode);
                acc.address       = i_address;
                acc.region_length = i_region_length;
                acc.perms         = i_perms_in;
                want = predict_region_result(acc);
                if (beat_pinned) want = beat_pin_res;
                pending_results.push_back(want);
            end
        end
    end

    function automatic t_dir_row mk_row(t_mode m, logic [31:0] a, logic [31:0] l,
                                        logic [2:0] p, bit pinned, logic st, t_kind k);
        t_dir_row r;
        r.item.mode          = m;
        r.item.address       = a;
        r.item.region_length = l;
        r.item.perms         = p;
        r.pinned             = pinned;
        r.res.status         = st;
        r.res.seg_kind       = k;
        r.res.perms          = 3'd0;
        r.res.found          = 1'b0;
        return r;
    endfunction

    function automatic t_dir_row open_row(t_mode m, logic [31:0] a, logic [31:0] l,
                                          logic [2:0] p);
        return mk_row(m, a, l, p, 1'b0, STATUS_OK, KIND_UNUSED);
    endfunction

    // lookup address aimed at region edges and the kernel boundary
    function automatic logic [31:0] probe_address();
        int          sel;
        int          idx;
        logic [31:0] off;
        sel = $urandom_range(0, 4);
        off = 32'($urandom_range(0, 6)) - 32'd3;
        if (sel == 0 || rgn_count == 0) return $urandom;
        if (sel == 1) return model_stack_top + off;
        idx = $urandom_range(0, rgn_count - 1);
        if (sel == 2) return rgn_base[idx] + off;
        if (sel == 3) return rgn_base[idx] + rgn_len[idx] + off;
        return rgn_base[idx] - rgn_len[idx] + off;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        it.address       = $urandom;
        it.region_length = $urandom;
        it.perms         = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            it.mode = MODE_DEFINE;
        end else if (pick < 12) begin
            it.mode = MODE_LOAD_BEGIN;
        end else if (pick < 18) begin
            it.mode = MODE_LOAD_END;
        end else begin
            it.mode    = MODE_LOOKUP;
            it.address = probe_address();
        end
        return it;
    endfunction

    // present one beat after a random gap and hold it until taken
    task automatic send_item(t_item it, bit pinned, t_result pin_res);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_mode          <= it.mode;
        i_address       <= it.address;
        i_region_length <= it.region_length;
        i_perms_in      <= it.perms;
        beat_pinned     <= pinned;
        beat_pin_res    <= pin_res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop sending and let every pending result come out
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stack_top(logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_dir_row    rows [$];
        logic [31:0] stack_tops [6];
        // empty table, loads with nothing stored
        rows.push_back(mk_row(MODE_LOOKUP, 32'h0000_0000, 32'h0, 3'd0, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1,
                              STATUS_OK, KIND_KERNEL));
        rows.push_back(mk_row(MODE_LOAD_BEGIN, 32'h0, 32'h0, 3'd0, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_LOAD_END, 32'h0, 32'h0, 3'd0, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        // code region widened by offset, stack region, zero length at equal base, wrap
        rows.push_back(mk_row(MODE_DEFINE, 32'h0040_0123, 32'h0000_1000, 3'd5, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_DEFINE, 32'h8000_0000, 32'h0001_0000, 3'd3, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_DEFINE, 32'h0040_0000, 32'h0000_0000, 3'd7, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_DEFINE, 32'h1000_0FFF, 32'hFFFF_FFFF, 3'd6, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        // region edges and stack bounds
        rows.push_back(open_row(MODE_LOOKUP, 32'h0040_0000, 32'h0, 3'd0));
        rows.push_back(open_row(MODE_LOOKUP, 32'h0040_1FFF, 32'h0, 3'd0));
        rows.push_back(open_row(MODE_LOOKUP, 32'h0040_2000, 32'h0, 3'd0));
        rows.push_back(open_row(MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0, 3'd0));
        rows.push_back(open_row(MODE_LOOKUP, 32'h7FFE_FFFF, 32'h0, 3'd0));
        rows.push_back(open_row(MODE_LOOKUP, 32'h7FFF_0000, 32'h0, 3'd0));
        rows.push_back(open_row(MODE_LOOKUP, 32'h8000_0000, 32'h0, 3'd0));
        // permissions opened up during a load, then restored
        rows.push_back(mk_row(MODE_LOAD_BEGIN, 32'h0, 32'h0, 3'd0, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(open_row(MODE_LOOKUP, 32'h0040_0800, 32'h0, 3'd0));
        rows.push_back(mk_row(MODE_LOAD_END, 32'h0, 32'h0, 3'd0, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(open_row(MODE_LOOKUP, 32'h0040_0800, 32'h0, 3'd0));
        // fill the table, then one define too many
        rows.push_back(mk_row(MODE_DEFINE, 32'hFFFF_F000, 32'h0000_2000, 3'd1, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_DEFINE, 32'h0000_0000, 32'h0000_0001, 3'd0, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_DEFINE, 32'h2000_0000, 32'h0000_3000, 3'd2, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_DEFINE, 32'h3000_0000, 32'h0000_0800, 3'd4, 1'b1,
                              STATUS_OK, KIND_UNUSED));
        rows.push_back(mk_row(MODE_DEFINE, 32'h4000_0000, 32'h0000_1000, 3'd7, 1'b1,
                              STATUS_FULL, KIND_UNUSED));
        rows.push_back(open_row(MODE_LOOKUP, 32'h1000_0800, 32'h0, 3'd0));

        stack_tops[0] = 32'hFFFF_FFFF;
        stack_tops[1] = 32'h0000_0000;
        stack_tops[2] = $urandom;
        stack_tops[3] = STACK_TOP_RV;
        stack_tops[4] = 32'h2000_0000;
        stack_tops[5] = 32'h0040_0800;

        // reset
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        in_idle_pct   = 21;
        out_stall_pct = 65;
        foreach (rows[r]) send_item(rows[r].item, rows[r].pinned, rows[r].res);
        settle();

        // random phases, one stack top each
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                in_idle_pct   = 21;
                out_stall_pct = 65;
            end else if (ph < 4) begin
                in_idle_pct   = 65;
                out_stall_pct = 21;
            end else begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            write_stack_top(stack_tops[ph]);
            for (int n = 0; n < PHASE_BEATS; n++) send_item(random_item(), 1'b0, '0);
            settle();
        end

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: address_region_table.f
sv/art_pkg.sv
sv/art_ram.sv
sv/art_engine.sv
sv/address_region_table.sv
tb/testbench.sv
